>>> rtl/cheat_code_line_interpreter_unit_assert.svh
// Assertion macros used by the cheat code line interpreter RTL.
`ifndef CHEAT_CODE_LINE_INTERPRETER_UNIT_ASSERT_SVH
`define CHEAT_CODE_LINE_INTERPRETER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CCLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define CCLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ccli_pkg.sv
// Types, codes and constants of the cheat code line interpreter.
package ccli_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned HalfW  = 16;
	localparam int unsigned InDataW  = 96;
	localparam int unsigned InUserW  = 3;
	localparam int unsigned OutDataW = 72;
	localparam int unsigned OutUserW = 3;

	typedef enum logic [1:0] {
		OPC_LINE      = 2'd0,
		OPC_READ_RESP = 2'd1,
		OPC_ADVANCE   = 2'd2,
		OPC_BAD       = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		BUS_NONE = 3'd0,
		BUS_WR8  = 3'd1,
		BUS_WR16 = 3'd2,
		BUS_WR32 = 3'd3,
		BUS_RD8  = 3'd4,
		BUS_RD16 = 3'd5,
		BUS_RD32 = 3'd6,
		BUS_RSVD = 3'd7
	} bus_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_UNEXP   = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMP_EQ8  = 2'd0,
		CMP_EQ16 = 2'd1,
		CMP_EQ32 = 2'd2,
		CMP_GT16 = 2'd3
	} cmp_kind_t;

	// Code type nibbles, first format
	localparam logic [3:0] F0_WR8   = 4'h0;
	localparam logic [3:0] F0_WR16  = 4'h1;
	localparam logic [3:0] F0_WR32  = 4'h2;
	localparam logic [3:0] F0_EQ8   = 4'h3;
	localparam logic [3:0] F0_SLIDE = 4'h6;
	localparam logic [3:0] F0_EQ16  = 4'hD;
	// Code type nibbles, second format
	localparam logic [3:0] F1_WR32  = 4'h0;
	localparam logic [3:0] F1_WR16  = 4'h1;
	localparam logic [3:0] F1_WR8   = 4'h2;
	localparam logic [3:0] F1_EQ32  = 4'h3;
	localparam logic [3:0] F1_GT16  = 4'h7;

	typedef struct packed {
		opcode_t           opcode;
		logic [WordW-1:0]  code_address_word;
		logic [WordW-1:0]  code_value_word;
		logic              code_format;
		logic              last_of_entry;
		logic [WordW-1:0]  read_data;
	} item_t;

	typedef struct packed {
		bus_op_t           bus_op;
		logic [WordW-1:0]  bus_address;
		logic [WordW-1:0]  bus_data;
		logic              slide_more;
		logic              read_wait;
		status_t           status;
	} result_t;

	typedef struct packed {
		logic              skip_flag;
		logic              slide_armed;
		logic [HalfW-1:0]  slide_remaining;
		logic [WordW-1:0]  slide_address;
		logic [HalfW-1:0]  slide_value;
		logic [HalfW-1:0]  slide_address_step;
		logic [HalfW-1:0]  slide_value_step;
		logic              awaiting_read;
		cmp_kind_t         compare_kind;
		logic [WordW-1:0]  compare_value;
		logic              compare_at_end;
	} state_t;

endpackage

>>> rtl/ccli_decode.sv
// Single-pass decode of one item: result and next interpreter state.
module ccli_decode (
	input  ccli_pkg::item_t   item,
	input  ccli_pkg::state_t  cur,
	output ccli_pkg::result_t res,
	output ccli_pkg::state_t  nxt
);

	logic [3:0]                  code_type;
	logic [ccli_pkg::WordW-1:0]  code_addr;
	logic [ccli_pkg::WordW-1:0]  vw;
	logic [ccli_pkg::WordW-1:0]  rd;
	logic [ccli_pkg::HalfW-1:0]  new_count;
	logic                        skip;

	assign code_type = item.code_address_word[31:28];
	assign code_addr = {4'b0, item.code_address_word[27:0]};
	assign vw        = item.code_value_word;
	assign rd        = item.read_data;
	assign new_count = item.code_address_word[31:16];

	always_comb begin
		unique case (cur.compare_kind)
			ccli_pkg::CMP_EQ8:  skip = {24'b0, rd[7:0]} != cur.compare_value;
			ccli_pkg::CMP_EQ16: skip = {16'b0, rd[15:0]} != cur.compare_value;
			ccli_pkg::CMP_EQ32: skip = rd != cur.compare_value;
			default:            skip = {16'b0, rd[15:0]} <= cur.compare_value;
		endcase
	end

	always_comb begin
		nxt             = cur;
		res.bus_op      = ccli_pkg::BUS_NONE;
		res.bus_address = '0;
		res.bus_data    = '0;
		res.status      = ccli_pkg::ST_OK;

		unique case (item.opcode)
			ccli_pkg::OPC_LINE: begin
				if (cur.awaiting_read || (cur.slide_remaining != '0)) begin
					res.status = ccli_pkg::ST_UNEXP;
				end else begin
					if (cur.slide_armed) begin
						// parameter line: latch steps and count, emit first write if the count is nonzero
						nxt.slide_armed        = 1'b0;
						nxt.slide_address_step = vw[31:16];
						nxt.slide_value_step   = vw[15:0];
						nxt.slide_remaining    = new_count;
						if (new_count != '0) begin
							nxt.slide_remaining = new_count - 16'd1;
							res.bus_op          = ccli_pkg::BUS_WR16;
							res.bus_address     = cur.slide_address;
							res.bus_data        = {16'b0, cur.slide_value};
							nxt.slide_address   = cur.slide_address + {16'b0, vw[31:16]};
							nxt.slide_value     = cur.slide_value + vw[15:0];
						end
					end else if (cur.skip_flag) begin
						nxt.skip_flag = 1'b0;
					end else if (!item.code_format) begin
						unique case (code_type)
							ccli_pkg::F0_WR8: begin
								res.bus_op      = ccli_pkg::BUS_WR8;
								res.bus_address = code_addr;
								res.bus_data    = {24'b0, vw[7:0]};
							end
							ccli_pkg::F0_WR16: begin
								res.bus_op      = ccli_pkg::BUS_WR16;
								res.bus_address = code_addr;
								res.bus_data    = {16'b0, vw[15:0]};
							end
							ccli_pkg::F0_WR32: begin
								res.bus_op      = ccli_pkg::BUS_WR32;
								res.bus_address = code_addr;
								res.bus_data    = vw;
							end
							ccli_pkg::F0_EQ8: begin
								res.bus_op         = ccli_pkg::BUS_RD8;
								res.bus_address    = code_addr;
								nxt.compare_kind   = ccli_pkg::CMP_EQ8;
								nxt.compare_value  = {24'b0, vw[7:0]};
								nxt.compare_at_end = item.last_of_entry;
								nxt.awaiting_read  = 1'b1;
							end
							ccli_pkg::F0_EQ16: begin
								res.bus_op         = ccli_pkg::BUS_RD16;
								res.bus_address    = code_addr;
								nxt.compare_kind   = ccli_pkg::CMP_EQ16;
								nxt.compare_value  = {16'b0, vw[15:0]};
								nxt.compare_at_end = item.last_of_entry;
								nxt.awaiting_read  = 1'b1;
							end
							ccli_pkg::F0_SLIDE: begin
								// a header at entry end has no parameter line: drop it
								if (!item.last_of_entry) begin
									nxt.slide_armed   = 1'b1;
									nxt.slide_address = code_addr;
									nxt.slide_value   = vw[15:0];
								end
							end
							default: res.status = ccli_pkg::ST_UNKNOWN;
						endcase
					end else begin
						unique case (code_type)
							ccli_pkg::F1_WR32: begin
								res.bus_op      = ccli_pkg::BUS_WR32;
								res.bus_address = code_addr;
								res.bus_data    = vw;
							end
							ccli_pkg::F1_WR16: begin
								res.bus_op      = ccli_pkg::BUS_WR16;
								res.bus_address = code_addr;
								res.bus_data    = {16'b0, vw[15:0]};
							end
							ccli_pkg::F1_WR8: begin
								res.bus_op      = ccli_pkg::BUS_WR8;
								res.bus_address = code_addr;
								res.bus_data    = {24'b0, vw[7:0]};
							end
							ccli_pkg::F1_EQ32: begin
								res.bus_op         = ccli_pkg::BUS_RD32;
								res.bus_address    = code_addr;
								nxt.compare_kind   = ccli_pkg::CMP_EQ32;
								nxt.compare_value  = vw;
								nxt.compare_at_end = item.last_of_entry;
								nxt.awaiting_read  = 1'b1;
							end
							ccli_pkg::F1_GT16: begin
								res.bus_op         = ccli_pkg::BUS_RD16;
								res.bus_address    = code_addr;
								nxt.compare_kind   = ccli_pkg::CMP_GT16;
								nxt.compare_value  = {16'b0, vw[15:0]};
								nxt.compare_at_end = item.last_of_entry;
								nxt.awaiting_read  = 1'b1;
							end
							default: res.status = ccli_pkg::ST_UNKNOWN;
						endcase
					end
					if (item.last_of_entry) begin
						nxt.skip_flag   = 1'b0;
						nxt.slide_armed = 1'b0;
					end
				end
			end
			ccli_pkg::OPC_READ_RESP: begin
				if (!cur.awaiting_read) begin
					res.status = ccli_pkg::ST_UNEXP;
				end else begin
					if (!cur.compare_at_end) begin
						nxt.skip_flag = skip;
					end
					nxt.awaiting_read = 1'b0;
				end
			end
			ccli_pkg::OPC_ADVANCE: begin
				if (cur.slide_remaining == '0) begin
					res.status = ccli_pkg::ST_UNEXP;
				end else begin
					nxt.slide_remaining = cur.slide_remaining - 16'd1;
					res.bus_op          = ccli_pkg::BUS_WR16;
					res.bus_address     = cur.slide_address;
					res.bus_data        = {16'b0, cur.slide_value};
					nxt.slide_address   = cur.slide_address + {16'b0, cur.slide_address_step};
					nxt.slide_value     = cur.slide_value + cur.slide_value_step;
				end
			end
			default: res.status = ccli_pkg::ST_UNEXP;
		endcase

		res.slide_more = nxt.slide_remaining != '0;
		res.read_wait  = nxt.awaiting_read;
	end

endmodule

>>> rtl/cheat_code_line_interpreter_unit.sv
// Cheat code line interpreter: turns cheat code lines into bus requests.
//
// Input stream (s_axis_*): one transaction per item. tuser carries the item
// kind (0 code line, 1 read response, 2 slide advance) and the code format,
// tlast marks the last code line of a cheat entry, tdata carries the two
// code words and the read data returned for a pending conditional.
// Output stream (m_axis_*): exactly one transaction per input item, in order.
// tuser is the bus request kind (none, write or read of 8/16/32 bits); tdata
// holds address, write data, the slide-pending and read-pending flags and a
// status code (ok, unknown type ignored, unexpected item ignored).
// An accepted item is registered in the input stage; its result is then
// loaded into the output register and offered on m_axis from there.
// Throughput: one item per cycle while the receiver does not stall; decode,
// compare and the slide adders sit between the input stage and the output
// register, and the interpreter state updates in the same cycle the result
// is loaded.
// When the receiver stalls, hold the result in the output register; the
// input stage still accepts one more item, then s_axis_tready drops until
// the output register drains.
// Reset clears the interpreter state (no skip, slide or read) and empties both stages.
module cheat_code_line_interpreter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] code_address_word, [63:32] code_value_word, [95:64] read_data
	input  logic [ccli_pkg::InDataW-1:0]    s_axis_tdata,
	// [1:0] opcode, [2] code_format
	input  logic [ccli_pkg::InUserW-1:0]    s_axis_tuser,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] bus_address, [63:32] bus_data, [64] slide_more, [65] read_wait,
	// [67:66] status, [71:68] zero
	output logic [ccli_pkg::OutDataW-1:0]   m_axis_tdata,
	// [2:0] bus_op
	output logic [ccli_pkg::OutUserW-1:0]   m_axis_tuser
);

	`include "cheat_code_line_interpreter_unit_assert.svh"

	logic               valid_s1;
	ccli_pkg::item_t    item_s1;
	logic               out_valid_q;
	ccli_pkg::result_t  result_q;
	ccli_pkg::state_t   state_q;
	ccli_pkg::state_t   state_nxt;
	ccli_pkg::result_t  result_nxt;
	logic               advance;
	logic               in_take;

	// The input stage moves on whenever the output register is free or draining.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// Input stage: control bit reset, payload loads on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.opcode            <= ccli_pkg::opcode_t'(s_axis_tuser[1:0]);
			item_s1.code_format       <= s_axis_tuser[2];
			item_s1.code_address_word <= s_axis_tdata[31:0];
			item_s1.code_value_word   <= s_axis_tdata[63:32];
			item_s1.read_data         <= s_axis_tdata[95:64];
			item_s1.last_of_entry     <= s_axis_tlast;
		end
	end

	ccli_decode u_decode (
		.item (item_s1),
		.cur  (state_q),
		.res  (result_nxt),
		.nxt  (state_nxt)
	);

	// Interpreter state: advance once per item as it leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q <= result_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = result_q.bus_op;
	assign m_axis_tdata  = {4'b0, result_q.status, result_q.read_wait, result_q.slide_more,
		result_q.bus_data, result_q.bus_address};

	// A conditional read and pending slide writes never coexist.
	`CCLI_ASSERT_NOW(a_no_read_and_slide, state_q.awaiting_read,
		state_q.slide_remaining == '0, "read pending while slide writes remain")

	// A read request always leaves the block waiting for its response.
	`CCLI_ASSERT_NOW(a_read_sets_wait,
		out_valid_q && (result_q.bus_op == ccli_pkg::BUS_RD8 ||
		result_q.bus_op == ccli_pkg::BUS_RD16 || result_q.bus_op == ccli_pkg::BUS_RD32),
		result_q.read_wait, "read request without read_wait")

	// An ignored item never produces a bus request.
	`CCLI_ASSERT_NOW(a_ignored_no_op, out_valid_q && result_q.status != ccli_pkg::ST_OK,
		result_q.bus_op == ccli_pkg::BUS_NONE, "bus request on ignored item")

	// A stalled item stays in the input stage.
	`CCLI_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !advance,
		valid_s1, "input stage lost an item under stall")

endmodule

>>> tb/sv/cheat_code_line_interpreter_unit_test.sv
// Testbench for the cheat code line interpreter: predicts every bus request and checks the stream.
`timescale 1ns / 1ps

import ccli_pkg::*;

// Tracks the interpreter state, predicts the bus request of each accepted item and
// checks the requests that come out of the block.
class bus_request_board;
	// Interpreter state, as the block should hold it after the last accepted item
	bit          skip_flag;
	bit          slide_armed;
	bit [15:0]   slide_remaining;
	bit [31:0]   slide_address;
	bit [15:0]   slide_value;
	bit [15:0]   slide_address_step;
	bit [15:0]   slide_value_step;
	bit          awaiting_read;
	cmp_kind_t   compare_kind;
	bit [31:0]   compare_value;
	bit          compare_at_end;

	result_t     pending[$];
	int unsigned mismatches;
	int unsigned ok_items;

	function new();
		compare_kind = CMP_EQ8;
	endfunction

	function bit busy();
		return awaiting_read || slide_remaining != 0 || slide_armed || skip_flag;
	endfunction

	function result_t write_request(bus_op_t op, bit [31:0] addr, bit [31:0] data);
		result_t r;
		r = '0;
		r.bus_op = op;
		r.bus_address = addr;
		r.bus_data = data;
		return r;
	endfunction

	function result_t read_request(cmp_kind_t kind, bit [31:0] addr, bit [31:0] value,
		bit at_end);
		result_t r;
		r = '0;
		compare_kind = kind;
		compare_value = value;
		compare_at_end = at_end;
		awaiting_read = 1'b1;
		r.bus_op = (kind == CMP_EQ8) ? BUS_RD8 : (kind == CMP_EQ32) ? BUS_RD32 : BUS_RD16;
		r.bus_address = addr;
		return r;
	endfunction

	// Emit the current slide write, then advance address and value.
	function result_t slide_write();
		result_t r;
		r = write_request(BUS_WR16, slide_address, {16'h0, slide_value});
		slide_address = slide_address + {16'h0, slide_address_step};
		slide_value = slide_value + slide_value_step;
		return r;
	endfunction

	function void accept_code_item(item_t it);
		result_t   r;
		bit [3:0]  kind;
		bit [31:0] addr;
		bit [31:0] aw;
		bit [31:0] vw;
		bit        skip;
		r = '0;
		aw = it.code_address_word;
		vw = it.code_value_word;
		kind = aw[31:28];
		addr = {4'h0, aw[27:0]};
		case (it.opcode)
			OPC_LINE: begin
				if (awaiting_read || slide_remaining != 0) begin
					r.status = ST_UNEXP;
				end else begin
					if (slide_armed) begin
						slide_armed = 1'b0;
						slide_address_step = vw[31:16];
						slide_value_step = vw[15:0];
						slide_remaining = aw[31:16];
						if (slide_remaining != 0) begin
							slide_remaining = slide_remaining - 16'd1;
							r = slide_write();
						end
					end else if (skip_flag) begin
						skip_flag = 1'b0;
					end else if (!it.code_format) begin
						case (kind)
							F0_WR8:   r = write_request(BUS_WR8, addr, {24'h0, vw[7:0]});
							F0_WR16:  r = write_request(BUS_WR16, addr, {16'h0, vw[15:0]});
							F0_WR32:  r = write_request(BUS_WR32, addr, vw);
							F0_EQ8:   r = read_request(CMP_EQ8, addr, {24'h0, vw[7:0]},
								it.last_of_entry);
							F0_EQ16:  r = read_request(CMP_EQ16, addr, {16'h0, vw[15:0]},
								it.last_of_entry);
							F0_SLIDE: begin
								if (!it.last_of_entry) begin
									slide_armed = 1'b1;
									slide_address = addr;
									slide_value = vw[15:0];
								end
							end
							default:  r.status = ST_UNKNOWN;
						endcase
					end else begin
						case (kind)
							F1_WR32:  r = write_request(BUS_WR32, addr, vw);
							F1_WR16:  r = write_request(BUS_WR16, addr, {16'h0, vw[15:0]});
							F1_WR8:   r = write_request(BUS_WR8, addr, {24'h0, vw[7:0]});
							F1_EQ32:  r = read_request(CMP_EQ32, addr, vw, it.last_of_entry);
							F1_GT16:  r = read_request(CMP_GT16, addr, {16'h0, vw[15:0]},
								it.last_of_entry);
							default:  r.status = ST_UNKNOWN;
						endcase
					end
					if (it.last_of_entry) begin
						skip_flag = 1'b0;
						slide_armed = 1'b0;
					end
				end
			end
			OPC_READ_RESP: begin
				if (!awaiting_read) begin
					r.status = ST_UNEXP;
				end else begin
					case (compare_kind)
						CMP_EQ8:  skip = {24'h0, it.read_data[7:0]} != compare_value;
						CMP_EQ16: skip = {16'h0, it.read_data[15:0]} != compare_value;
						CMP_EQ32: skip = it.read_data != compare_value;
						default:  skip = {16'h0, it.read_data[15:0]} <= compare_value;
					endcase
					if (!compare_at_end)
						skip_flag = skip;
					awaiting_read = 1'b0;
				end
			end
			OPC_ADVANCE: begin
				if (slide_remaining == 0) begin
					r.status = ST_UNEXP;
				end else begin
					slide_remaining = slide_remaining - 16'd1;
					r = slide_write();
				end
			end
			default: r.status = ST_UNEXP;
		endcase
		r.slide_more = slide_remaining != 0;
		r.read_wait = awaiting_read;
		if (r.status == ST_OK)
			ok_items++;
		pending.push_back(r);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	function void check_bus_request(logic [2:0] op, logic [71:0] data);
		result_t want;
		if (pending.size() == 0) begin
			$error("bus request with none predicted: op %h data %h", op, data);
			mismatches++;
			return;
		end
		want = pending.pop_front();
		compare_field("bus_op", 32'(want.bus_op), 32'(op));
		compare_field("bus_address", want.bus_address, data[31:0]);
		compare_field("bus_data", want.bus_data, data[63:32]);
		compare_field("slide_more", 32'(want.slide_more), 32'(data[64]));
		compare_field("read_wait", 32'(want.read_wait), 32'(data[65]));
		compare_field("status", 32'(want.status), 32'(data[67:66]));
		compare_field("pad", 32'h0, 32'(data[71:68]));
	endfunction
endclass

module cheat_code_line_interpreter_unit_test;

	// Receiver hold-off for the back-pressure phase, and the quiet-cycle limit of the
	// watchdog. The hold-off is the longest legal quiet stretch, so the limit sits well
	// above it.
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned SETTLE_CYCLES = 10;

	localparam logic [3:0] F0_KINDS [6] = '{F0_WR8, F0_WR16, F0_WR32, F0_EQ8, F0_EQ16,
		F0_SLIDE};
	localparam logic [3:0] F1_KINDS [5] = '{F1_WR32, F1_WR16, F1_WR8, F1_EQ32, F1_GT16};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [InDataW-1:0]   s_axis_tdata = '0;
	logic [InUserW-1:0]   s_axis_tuser = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OutDataW-1:0]  m_axis_tdata;
	logic [OutUserW-1:0]  m_axis_tuser;

	bus_request_board     requests;
	bit                   sender_gaps = 1'b1;
	bit                   receiver_gaps = 1'b1;
	bit                   hold_request = 1'b0;
	int unsigned          quiet_cycles = 0;

	cheat_code_line_interpreter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic item_t code_item(opcode_t op, logic [31:0] aw, logic [31:0] vw,
		logic fmt, logic last, logic [31:0] rd);
		item_t it;
		it.opcode = op;
		it.code_address_word = aw;
		it.code_value_word = vw;
		it.code_format = fmt;
		it.last_of_entry = last;
		it.read_data = rd;
		return it;
	endfunction

	// Build the next item from the predicted state: mostly what a well-formed cheat
	// stream would carry next (response to a pending read, advance of a running slide,
	// parameter line after a slide header, known code types), with some noise mixed in.
	function automatic item_t next_item();
		item_t       it;
		int unsigned pick;
		logic [3:0]  kind;
		bit          multi_line;
		it = code_item(OPC_LINE, $urandom, $urandom, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), $urandom);
		pick = $urandom_range(0, 15);
		if (pick >= 14) begin
			it.opcode = opcode_t'($urandom_range(0, 3));
		end else if (requests.awaiting_read) begin
			it.opcode = OPC_READ_RESP;
			// Half of the responses hit the compare value, or sit right around it
			if ($urandom_range(0, 1)) begin
				case (requests.compare_kind)
					CMP_EQ8:  it.read_data[7:0] = requests.compare_value[7:0];
					CMP_EQ16: it.read_data[15:0] = requests.compare_value[15:0];
					CMP_EQ32: it.read_data = requests.compare_value;
					default:  it.read_data[15:0] = requests.compare_value[15:0]
						+ 16'($urandom_range(0, 2)) - 16'd1;
				endcase
			end
		end else if (requests.slide_remaining != 0) begin
			it.opcode = OPC_ADVANCE;
		end else if (requests.slide_armed) begin
			// Keep slides short; a count of zero shows up now and then
			it.code_address_word[31:16] = 16'($urandom_range(0, 5));
		end else if (pick >= 2) begin
			if (it.code_format)
				kind = F1_KINDS[$urandom_range(0, 4)];
			else
				kind = F0_KINDS[$urandom_range(0, 5)];
			it.code_address_word[31:28] = kind;
			multi_line = it.code_format ? (kind inside {F1_EQ32, F1_GT16})
				: (kind inside {F0_EQ8, F0_EQ16, F0_SLIDE});
			if (multi_line)
				it.last_of_entry = ($urandom_range(0, 3) == 0);
		end
		return it;
	endfunction

	// Offer one item, hold it until the transaction completes, then note it.
	task automatic send_item(item_t it);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {it.read_data, it.code_value_word, it.code_address_word};
		s_axis_tuser <= {it.code_format, it.opcode};
		s_axis_tlast <= it.last_of_entry;
		do
			@(posedge clk);
		while (!s_axis_tready);
		requests.accept_code_item(it);
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted request has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (requests.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(int unsigned count);
		int unsigned target;
		target = requests.ok_items + count;
		while (requests.ok_items < target)
			send_item(next_item());
	endtask

	// Walk every code type, both formats and each corner of the conditional and slide
	// handling.
	task automatic send_directed();
		// Plain writes of both formats at the field extremes
		send_item(code_item(OPC_LINE, 32'h0FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0));
		send_item(code_item(OPC_LINE, 32'h1000_0000, 32'h1234_5678, 1'b0, 1'b1, 32'h0));
		send_item(code_item(OPC_LINE, 32'h2ABC_DEF0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0));
		send_item(code_item(OPC_LINE, 32'h1ABC_DEF0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0));
		send_item(code_item(OPC_LINE, 32'h2FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0));
		// Unknown types; the slide nibble means nothing in the second format
		send_item(code_item(OPC_LINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0));
		send_item(code_item(OPC_LINE, 32'h6000_1234, 32'h0000_0001, 1'b1, 1'b1, 32'h0));
		// Equal compare that passes; a line while the read is out gets rejected
		send_item(code_item(OPC_LINE, 32'h3000_0100, 32'h0000_00AB, 1'b0, 1'b0, 32'h0));
		send_item(code_item(OPC_LINE, 32'h0000_0010, 32'h0, 1'b0, 1'b0, 32'h0));
		send_item(code_item(OPC_READ_RESP, 32'h0, 32'h0, 1'b0, 1'b0, 32'hFFFF_FFAB));
		// Failing 32-bit compare skips exactly one line: the slide header, so its
		// parameter line decodes as a write of its own
		send_item(code_item(OPC_LINE, 32'h3000_0200, 32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0));
		send_item(code_item(OPC_READ_RESP, 32'h0, 32'h0, 1'b0, 1'b0, 32'hDEAD_BEEE));
		send_item(code_item(OPC_LINE, 32'h6000_0300, 32'h0000_1111, 1'b0, 1'b0, 32'h0));
		send_item(code_item(OPC_LINE, 32'h0003_0040, 32'h0000_00FF, 1'b0, 1'b1, 32'h0));
		// Stray response, reserved opcode, advance with nothing left
		send_item(code_item(OPC_READ_RESP, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0));
		send_item(code_item(OPC_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
		send_item(code_item(OPC_ADVANCE, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0));
		// Two-write slide, and a line rejected in between
		send_item(code_item(OPC_LINE, 32'h6123_4566, 32'h0000_FFFE, 1'b0, 1'b0, 32'h0));
		send_item(code_item(OPC_LINE, 32'h0002_0000, 32'hFFFF_0001, 1'b0, 1'b0, 32'h0));
		send_item(code_item(OPC_LINE, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0));
		send_item(code_item(OPC_ADVANCE, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0));
		// Slide header closing its entry, then a slide of zero writes
		send_item(code_item(OPC_LINE, 32'h6000_0500, 32'h0000_0005, 1'b0, 1'b1, 32'h0));
		send_item(code_item(OPC_LINE, 32'h6000_0600, 32'h0000_0006, 1'b0, 1'b0, 32'h0));
		send_item(code_item(OPC_LINE, 32'h0000_0000, 32'h0001_0001, 1'b0, 1'b1, 32'h0));
		// Compare at entry end: a miss must not skip anything
		send_item(code_item(OPC_LINE, 32'hD000_0700, 32'h0000_8000, 1'b0, 1'b1, 32'h0));
		send_item(code_item(OPC_READ_RESP, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0000_1234));
		// Greater-than compare that passes, then the guarded write
		send_item(code_item(OPC_LINE, 32'h7000_0800, 32'h0000_1234, 1'b1, 1'b0, 32'h0));
		send_item(code_item(OPC_READ_RESP, 32'h0, 32'h0, 1'b0, 1'b0, 32'hFFFF_1235));
		send_item(code_item(OPC_LINE, 32'h0000_0900, 32'h0, 1'b1, 1'b1, 32'h0));
	endtask

	// A long slide with the widest steps, so the value wraps on every write.
	task automatic send_long_slide();
		while (requests.busy())
			send_item(next_item());
		send_item(code_item(OPC_LINE, {F0_SLIDE, 28'hFFF_FFFF}, 32'h0000_FFFF, 1'b0, 1'b0,
			$urandom));
		send_item(code_item(OPC_LINE, {16'd64, 16'($urandom)}, 32'hFFFF_FFFF, 1'b0, 1'b0,
			$urandom));
		while (requests.slide_remaining != 0)
			send_item(code_item(OPC_ADVANCE, $urandom, $urandom, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom));
	endtask

	// Receiver: random stall bursts, and one long hold-off on request so the block
	// backs up and stalls its input.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
				hold_request = 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Check each completed output transaction; end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				requests.check_bus_request(m_axis_tuser, m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		requests = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		send_random(750);

		// Back-pressure: keep offering items while the receiver holds off
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		repeat (40) send_item(next_item());
		sender_gaps = 1'b1;
		// Pause the sender until every request has come out
		drain();
		@(posedge clk);

		send_random(650);

		// Final stretch at full rate on both sides
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		send_random(200);
		send_long_slide();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (requests.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
